### sv/pprd_pkg.sv
// Shared types, widths and helpers for the pinhole projector with radial distortion.
// No dependencies.
package pprd_pkg;

  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned HW = 50;
  localparam int unsigned NumW = HW + 16;
  localparam int unsigned QW = 39;
  localparam int unsigned DivN = QW;
  localparam int unsigned PostN = 14;
  localparam logic [QW-1:0] QuotMax = '1;
  localparam logic [63:0] OneQ48 = 64'h0001_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0_XY = 4'd0,
    CFG_ROW0_ZW = 4'd1,
    CFG_ROW1_XY = 4'd2,
    CFG_ROW1_ZW = 4'd3,
    CFG_ROW2_XY = 4'd4,
    CFG_ROW2_ZW = 4'd5,
    CFG_DIST    = 4'd6,
    CFG_INV_F2  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic          dz;
    logic          front;
    logic          un;
    logic          vn;
    logic          satu;
    logic          satv;
    logic [HW-1:0] aw;
    logic [NumW-1:0] ru;
    logic [NumW-1:0] rv;
    logic [QW-1:0] qu;
    logic [QW-1:0] qv;
  } div_t;

  typedef struct packed {
    logic             dz;
    logic             front;
    logic             un;
    logic             vn;
    logic             dist_en;
    logic             bad_r;
    logic             apply;
    logic [QW-1:0]    uq;
    logic [QW-1:0]    vq;
    logic [31:0]      ux;
    logic [31:0]      vx;
    logic [5:0][39:0] psq;
    logic [78:0]      su;
    logic [78:0]      sv;
    logic [78:0]      s;
    logic [5:0][50:0] pg;
    logic [126:0]     pa;
    logic [126:0]     pb;
    logic [27:0]      rsq;
    logic [30:0]      rsq2;
    logic [60:0]      k0r;
    logic [63:0]      k1r;
    logic [63:0]      factor;
    logic [3:0][51:0] px;
    logic [3:0][51:0] py;
    logic [101:0]     xa;
    logic [101:0]     xb;
    logic [101:0]     ya;
    logic [101:0]     yb;
    logic [101:0]     prx;
    logic [101:0]     pry;
    logic [31:0]      ox;
    logic [31:0]      oy;
  } ctx_t;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic        front;
    logic        dz;
    logic        applied;
  } res_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [53:0] mag);
    logic [53:0] m;
    m = (mag > 54'h8000_0000) ? 54'h8000_0000 : mag;
    if (neg) begin
      sat32 = 32'(54'd0 - m);
    end else begin
      sat32 = (mag > 54'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  endfunction

endpackage

### sv/pinhole_project_radial_distort_top.sv
// An item moves through the product, row-sum, divider and post-divide registers in that order.
// Throughput: one item per cycle while in_stall_o is low; the 39-stage
// restoring divider and split multipliers are fully pipelined and keep that rate.
// A one-entry skid register at the output lets one more item drain while stalled.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// identity-like projection; distortion and inverse focal square reset to zero.
module pinhole_project_radial_distort_top
  import pprd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  image_x_o,
  output logic signed [31:0]  image_y_o,
  output logic                point_ahead_o,
  output logic                depth_zero_o,
  output logic                distortion_applied_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  logic [NumCfg-1:0][63:0] cfg_q;
  logic en;

  logic [2:0][2:0][47:0] p_d, p_q;
  logic [2:0][HW-1:0]    h_d, h_q;
  logic                  v1_q, v2_q;

  div_t div_q [DivN+1];
  logic dvld_q [DivN+1];
  div_t div0_d;

  ctx_t ctx_d [PostN];
  ctx_t ctx_q [PostN];
  logic [PostN-1:0] pvld_q;

  res_t res_last;
  res_t skid_q;
  logic skid_v_q;

  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {64'd0, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
                64'd0, 64'h0000_0000_0001_0000, 64'd0, 64'h0001_0000_0000_0000};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW0_XY: cfg_q[CFG_ROW0_XY] <= cfg_data_i;
        CFG_ROW0_ZW: cfg_q[CFG_ROW0_ZW] <= cfg_data_i;
        CFG_ROW1_XY: cfg_q[CFG_ROW1_XY] <= cfg_data_i;
        CFG_ROW1_ZW: cfg_q[CFG_ROW1_ZW] <= cfg_data_i;
        CFG_ROW2_XY: cfg_q[CFG_ROW2_XY] <= cfg_data_i;
        CFG_ROW2_ZW: cfg_q[CFG_ROW2_ZW] <= cfg_data_i;
        CFG_DIST:    cfg_q[CFG_DIST]    <= cfg_data_i;
        CFG_INV_F2:  cfg_q[CFG_INV_F2]  <= {16'd0, cfg_data_i[47:0]};
        default: ;
      endcase
    end
  end

  // matrix products, floored to Q32.16
  always_comb begin
    logic signed [31:0] pt [3];
    logic signed [63:0] prod;
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int r = 0; r < 3; r++) begin
      prod = $signed(cfg_q[2*r][63:32]) * pt[0];
      p_d[r][0] = prod[63:16];
      prod = $signed(cfg_q[2*r][31:0]) * pt[1];
      p_d[r][1] = prod[63:16];
      prod = $signed(cfg_q[2*r+1][63:32]) * pt[2];
      p_d[r][2] = prod[63:16];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h_d[r] = HW'($signed(p_q[r][0])) + HW'($signed(p_q[r][1]))
             + HW'($signed(p_q[r][2])) + HW'($signed(cfg_q[2*r+1][31:0]));
    end
  end

  // magnitudes, signs and quotient overflow
  always_comb begin
    logic [HW-1:0] mu, mv;
    div0_d       = '0;
    div0_d.dz    = (h_q[2] == '0);
    div0_d.front = h_q[2][HW-1];
    div0_d.un    = (h_q[0][HW-1] == h_q[2][HW-1]);
    div0_d.vn    = (h_q[1][HW-1] == h_q[2][HW-1]);
    div0_d.aw    = h_q[2][HW-1] ? HW'(-h_q[2]) : h_q[2];
    mu           = h_q[0][HW-1] ? HW'(-h_q[0]) : h_q[0];
    mv           = h_q[1][HW-1] ? HW'(-h_q[1]) : h_q[1];
    div0_d.ru    = {mu, 16'd0};
    div0_d.rv    = {mv, 16'd0};
    div0_d.satu  = ({{QW{1'b0}}, mu, 16'd0} >= {16'd0, div0_d.aw, {QW{1'b0}}});
    div0_d.satv  = ({{QW{1'b0}}, mv, 16'd0} >= {16'd0, div0_d.aw, {QW{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      dvld_q[0] <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      dvld_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q      <= p_d;
      h_q      <= h_d;
      div_q[0] <= div0_d;
    end
  end

  for (genvar i = 0; i < DivN; i++) begin : g_div
    localparam int unsigned B = DivN - 1 - i;
    div_t nxt;
    always_comb begin
      logic [NumW+QW-1:0] dvs;
      nxt = div_q[i];
      dvs = (NumW+QW)'(div_q[i].aw) << B;
      if ((NumW+QW)'(div_q[i].ru) >= dvs) begin
        nxt.ru    = NumW'((NumW+QW)'(div_q[i].ru) - dvs);
        nxt.qu[B] = 1'b1;
      end
      if ((NumW+QW)'(div_q[i].rv) >= dvs) begin
        nxt.rv    = NumW'((NumW+QW)'(div_q[i].rv) - dvs);
        nxt.qv[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[i+1] <= 1'b0;
      end else if (en) begin
        dvld_q[i+1] <= dvld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i+1] <= nxt;
      end
    end
  end

  // squares, radius, factor, scaling, output select
  always_comb begin
    div_t        dl;
    logic [31:0] k0, k1;
    logic [47:0] g;
    logic [126:0] pf;
    logic [70:0] hp;
    logic [55:0] r2;
    logic [31:0] sxo, syo;
    dl = div_q[DivN];
    k0 = cfg_q[CFG_DIST][63:32];
    k1 = cfg_q[CFG_DIST][31:0];
    g  = cfg_q[CFG_INV_F2][47:0];

    ctx_d[0]         = '0;
    ctx_d[0].dz      = dl.dz;
    ctx_d[0].front   = dl.front;
    ctx_d[0].un      = dl.un;
    ctx_d[0].vn      = dl.vn;
    ctx_d[0].uq      = dl.satu ? QuotMax : dl.qu;
    ctx_d[0].vq      = dl.satv ? QuotMax : dl.qv;
    ctx_d[0].ux      = sat32(dl.un, 54'(ctx_d[0].uq));
    ctx_d[0].vx      = sat32(dl.vn, 54'(ctx_d[0].vq));
    ctx_d[0].dist_en = !dl.dz && ((k0 != '0) || (k1 != '0));

    ctx_d[1] = ctx_q[0];
    ctx_d[1].psq[0] = 40'(ctx_q[0].uq[38:19]) * 40'(ctx_q[0].uq[38:19]);
    ctx_d[1].psq[1] = 40'(ctx_q[0].uq[38:19]) * 40'(ctx_q[0].uq[18:0]);
    ctx_d[1].psq[2] = 40'(ctx_q[0].uq[18:0]) * 40'(ctx_q[0].uq[18:0]);
    ctx_d[1].psq[3] = 40'(ctx_q[0].vq[38:19]) * 40'(ctx_q[0].vq[38:19]);
    ctx_d[1].psq[4] = 40'(ctx_q[0].vq[38:19]) * 40'(ctx_q[0].vq[18:0]);
    ctx_d[1].psq[5] = 40'(ctx_q[0].vq[18:0]) * 40'(ctx_q[0].vq[18:0]);

    ctx_d[2] = ctx_q[1];
    ctx_d[2].su = (79'(ctx_q[1].psq[0]) << 38) + (79'(ctx_q[1].psq[1]) << 20)
                + 79'(ctx_q[1].psq[2]);
    ctx_d[2].sv = (79'(ctx_q[1].psq[3]) << 38) + (79'(ctx_q[1].psq[4]) << 20)
                + 79'(ctx_q[1].psq[5]);

    ctx_d[3] = ctx_q[2];
    ctx_d[3].s = ctx_q[2].su + ctx_q[2].sv;

    ctx_d[4] = ctx_q[3];
    ctx_d[4].pg[0] = 51'(ctx_q[3].s[26:0]) * 51'(g[23:0]);
    ctx_d[4].pg[1] = 51'(ctx_q[3].s[26:0]) * 51'(g[47:24]);
    ctx_d[4].pg[2] = 51'(ctx_q[3].s[53:27]) * 51'(g[23:0]);
    ctx_d[4].pg[3] = 51'(ctx_q[3].s[53:27]) * 51'(g[47:24]);
    ctx_d[4].pg[4] = 51'(ctx_q[3].s[78:54]) * 51'(g[23:0]);
    ctx_d[4].pg[5] = 51'(ctx_q[3].s[78:54]) * 51'(g[47:24]);

    ctx_d[5] = ctx_q[4];
    ctx_d[5].pa = 127'(ctx_q[4].pg[0]) + (127'(ctx_q[4].pg[1]) << 24)
                + (127'(ctx_q[4].pg[2]) << 27);
    ctx_d[5].pb = (127'(ctx_q[4].pg[3]) << 51) + (127'(ctx_q[4].pg[4]) << 54)
                + (127'(ctx_q[4].pg[5]) << 78);

    ctx_d[6] = ctx_q[5];
    pf = ctx_q[5].pa + ctx_q[5].pb;
    hp = pf[126:56];
    ctx_d[6].bad_r = (hp > 71'h800_0000);
    ctx_d[6].rsq   = hp[27:0];

    ctx_d[7] = ctx_q[6];
    r2 = 56'(ctx_q[6].rsq) * 56'(ctx_q[6].rsq);
    ctx_d[7].rsq2 = r2[54:24];
    ctx_d[7].k0r  = 61'($signed(k0)) * 61'($signed({1'b0, ctx_q[6].rsq}));

    ctx_d[8] = ctx_q[7];
    ctx_d[8].k1r = 64'($signed(k1)) * 64'($signed({1'b0, ctx_q[7].rsq2}));

    ctx_d[9] = ctx_q[8];
    ctx_d[9].factor = OneQ48 + 64'($signed(ctx_q[8].k0r)) + ctx_q[8].k1r;
    ctx_d[9].apply  = ctx_q[8].dist_en && !ctx_q[8].bad_r && !ctx_d[9].factor[63];

    ctx_d[10] = ctx_q[9];
    ctx_d[10].px[0] = 52'(ctx_q[9].uq[38:19]) * 52'(ctx_q[9].factor[31:0]);
    ctx_d[10].px[1] = 52'(ctx_q[9].uq[38:19]) * 52'(ctx_q[9].factor[62:32]);
    ctx_d[10].px[2] = 52'(ctx_q[9].uq[18:0]) * 52'(ctx_q[9].factor[31:0]);
    ctx_d[10].px[3] = 52'(ctx_q[9].uq[18:0]) * 52'(ctx_q[9].factor[62:32]);
    ctx_d[10].py[0] = 52'(ctx_q[9].vq[38:19]) * 52'(ctx_q[9].factor[31:0]);
    ctx_d[10].py[1] = 52'(ctx_q[9].vq[38:19]) * 52'(ctx_q[9].factor[62:32]);
    ctx_d[10].py[2] = 52'(ctx_q[9].vq[18:0]) * 52'(ctx_q[9].factor[31:0]);
    ctx_d[10].py[3] = 52'(ctx_q[9].vq[18:0]) * 52'(ctx_q[9].factor[62:32]);

    ctx_d[11] = ctx_q[10];
    ctx_d[11].xa = (102'(ctx_q[10].px[1]) << 51) + (102'(ctx_q[10].px[3]) << 32);
    ctx_d[11].xb = (102'(ctx_q[10].px[0]) << 19) + 102'(ctx_q[10].px[2]);
    ctx_d[11].ya = (102'(ctx_q[10].py[1]) << 51) + (102'(ctx_q[10].py[3]) << 32);
    ctx_d[11].yb = (102'(ctx_q[10].py[0]) << 19) + 102'(ctx_q[10].py[2]);

    ctx_d[12] = ctx_q[11];
    ctx_d[12].prx = ctx_q[11].xa + ctx_q[11].xb;
    ctx_d[12].pry = ctx_q[11].ya + ctx_q[11].yb;

    ctx_d[13] = ctx_q[12];
    sxo = sat32(ctx_q[12].un, ctx_q[12].prx[101:48]);
    syo = sat32(ctx_q[12].vn, ctx_q[12].pry[101:48]);
    ctx_d[13].ox = ctx_q[12].dz ? 32'd0 : (ctx_q[12].apply ? sxo : ctx_q[12].ux);
    ctx_d[13].oy = ctx_q[12].dz ? 32'd0 : (ctx_q[12].apply ? syo : ctx_q[12].vx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
    end else if (en) begin
      pvld_q <= {pvld_q[PostN-2:0], dvld_q[DivN]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < PostN; k++) begin
        ctx_q[k] <= ctx_d[k];
      end
    end
  end

  assign res_last.ox      = ctx_q[PostN-1].ox;
  assign res_last.oy      = ctx_q[PostN-1].oy;
  assign res_last.front   = ctx_q[PostN-1].front;
  assign res_last.dz      = ctx_q[PostN-1].dz;
  assign res_last.applied = ctx_q[PostN-1].apply;

  // hold the last item aside when the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (pvld_q[PostN-1] && out_stall_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_q <= res_last;
    end
  end

  assign out_valid_o          = skid_v_q || pvld_q[PostN-1];
  assign image_x_o            = skid_v_q ? skid_q.ox : res_last.ox;
  assign image_y_o            = skid_v_q ? skid_q.oy : res_last.oy;
  assign point_ahead_o        = skid_v_q ? skid_q.front : res_last.front;
  assign depth_zero_o         = skid_v_q ? skid_q.dz : res_last.dz;
  assign distortion_applied_o = skid_v_q ? skid_q.applied : res_last.applied;

`ifndef ASSERT_OFF
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> !skid_v_q)
    else $error("skid entry not released");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_zero_o) |->
      (image_x_o == 32'sd0 && image_y_o == 32'sd0 && !distortion_applied_o &&
       !point_ahead_o))
    else $error("zero depth result not cleared");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost at first stage");
`endif

endmodule

### sim/pinhole_project_radial_distort_top_tb.sv
// Self-checking testbench for pinhole_project_radial_distort_top: a directed table, then
// random points under several projection and distortion settings, with a bit-exact predictor.
// Depends on pprd_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module pinhole_project_radial_distort_top_tb;
  import pprd_pkg::*;

  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [63:0] RsqLimit = 64'd8 << 24;
  localparam int unsigned DrainCycles = 70;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 75;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    res_t        res;
  } point_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] point_x_i;
  logic [31:0] point_y_i;
  logic [31:0] point_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] image_x_o;
  logic [31:0] image_y_o;
  logic        point_ahead_o;
  logic        depth_zero_o;
  logic        distortion_applied_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;

  logic [63:0] cam_regs [NumCfg];
  res_t        image_q [$];
  int unsigned fail_cnt;
  int unsigned point_cnt;
  int unsigned image_cnt;
  int unsigned distorted_cnt;
  int unsigned dz_cnt;
  bit          no_idle;
  bit          hold_req;

  pinhole_project_radial_distort_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .point_x_i           (point_x_i),
    .point_y_i           (point_y_i),
    .point_z_i           (point_z_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .image_x_o           (image_x_o),
    .image_y_o           (image_y_o),
    .point_ahead_o       (point_ahead_o),
    .depth_zero_o        (depth_zero_o),
    .distortion_applied_o(distortion_applied_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout with %0d images outstanding", image_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] clamp_q16(input bit neg, input logic [63:0] mag);
    logic [63:0] m;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      clamp_q16 = 32'(64'd0 - m);
    end else begin
      clamp_q16 = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  endfunction

  function automatic longint row_sum(input int r, input longint px, input longint py,
                                     input longint pz);
    logic [63:0] xy;
    logic [63:0] zw;
    longint      acc;
    xy = cam_regs[2*r];
    zw = cam_regs[2*r+1];
    acc = longint'(signed'(zw[31:0]));
    acc += (longint'(signed'(xy[63:32])) * px) >>> 16;
    acc += (longint'(signed'(xy[31:0])) * py) >>> 16;
    acc += (longint'(signed'(zw[63:32])) * pz) >>> 16;
    return acc;
  endfunction

  function automatic logic [63:0] scale_mag(input logic [63:0] mag, input longint fac);
    logic [127:0] prod;
    prod = 128'(mag) * 128'(fac);
    if (prod[127:112] != '0) return '1;
    return prod[111:48];
  endfunction

  function automatic res_t project_point(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
    longint       h0;
    longint       h1;
    longint       w;
    longint       k0;
    longint       k1;
    longint       fac;
    logic [127:0] aw;
    logic [127:0] sq;
    logic [127:0] pw;
    logic [63:0]  uq;
    logic [63:0]  vq;
    logic [63:0]  rsq;
    logic [63:0]  rsq2;
    bit           un;
    bit           vn;
    res_t         r;
    h0 = row_sum(0, signed'(x), signed'(y), signed'(z));
    h1 = row_sum(1, signed'(x), signed'(y), signed'(z));
    w  = row_sum(2, signed'(x), signed'(y), signed'(z));
    r = '0;
    if (w == 0) begin
      r.dz = 1'b1;
      return r;
    end
    r.front = (w < 0);
    aw = 128'((w < 0) ? -w : w);
    uq = 64'((128'((h0 < 0) ? -h0 : h0) << 16) / aw);
    vq = 64'((128'((h1 < 0) ? -h1 : h1) << 16) / aw);
    if (uq > 64'(QuotMax)) uq = 64'(QuotMax);
    if (vq > 64'(QuotMax)) vq = 64'(QuotMax);
    un = ((h0 < 0) == (w < 0));
    vn = ((h1 < 0) == (w < 0));
    r.ox = clamp_q16(un, uq);
    r.oy = clamp_q16(vn, vq);
    k0 = longint'(signed'(cam_regs[CFG_DIST][63:32]));
    k1 = longint'(signed'(cam_regs[CFG_DIST][31:0]));
    if (k0 == 0 && k1 == 0) return r;
    sq = 128'(uq) * 128'(uq) + 128'(vq) * 128'(vq);
    pw = sq * 128'(cam_regs[CFG_INV_F2][47:0]);
    if (pw[127:120] != '0) return r;
    rsq = pw[119:56];
    if (rsq > RsqLimit) return r;
    rsq2 = (rsq * rsq) >> 24;
    fac = longint'(OneQ48) + k0 * longint'(rsq) + k1 * longint'(rsq2);
    if (fac < 0) return r;
    r.ox = clamp_q16(un, scale_mag(uq, fac));
    r.oy = clamp_q16(vn, scale_mag(vq, fac));
    r.applied = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("image %0d: %s got %h want %h", image_cnt, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (image_q.size() == 0) begin
        report_mismatch("image with no point pending", 32'd1, 32'd0);
      end else begin
        want = image_q.pop_front();
        if (image_x_o !== want.ox) report_mismatch("image_x", image_x_o, want.ox);
        if (image_y_o !== want.oy) report_mismatch("image_y", image_y_o, want.oy);
        if (point_ahead_o !== want.front)
          report_mismatch("point_ahead", 32'(point_ahead_o), 32'(want.front));
        if (depth_zero_o !== want.dz)
          report_mismatch("depth_zero", 32'(depth_zero_o), 32'(want.dz));
        if (distortion_applied_o !== want.applied)
          report_mismatch("distortion_applied", 32'(distortion_applied_o),
                          32'(want.applied));
        if (want.applied) distorted_cnt++;
        if (want.dz) dz_cnt++;
      end
      image_cnt++;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 23);
    end
  end

  task automatic offer_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit known, input res_t res);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    image_q.push_back(known ? res : project_point(x, y, z));
    point_cnt++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (image_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [63:0] vals [NumCfg]);
    for (int i = 0; i < NumCfg; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cam_regs[i] = (cfg_idx_e'(i) == CFG_INV_F2) ? {16'd0, vals[i][47:0]} : vals[i];
    end
    // an index past the bank must leave every register untouched
    cfg_index_i <= CfgIdxW'(NumCfg + 1);
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_q16(input int unsigned span);
    return 32'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  task automatic offer_random(input int unsigned n);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    int unsigned pick;
    res_t        none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      x = near_q16(3 * OneQ16);
      y = near_q16(3 * OneQ16);
      z = 32'($urandom_range(4 * OneQ16, OneQ16 / 2));
      if ($urandom_range(99) < 75) z = -z;
      if (pick < 8) begin
        z = '0;
      end else if (pick < 25) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else if (pick < 30) begin
        z = near_q16(3);
      end
      offer_point(x, y, z, 1'b0, none);
    end
  endtask

  task automatic camera_regs(output logic [63:0] vals [NumCfg], input int k0_lo,
                             input int k0_hi);
    logic [31:0] f;
    f = $urandom_range(800, 100);
    vals[CFG_ROW0_XY] = {f << 16, 32'd0};
    vals[CFG_ROW0_ZW] = {near_q16(OneQ16 / 4), near_q16(OneQ16)};
    vals[CFG_ROW1_XY] = {32'd0, f << 16};
    vals[CFG_ROW1_ZW] = {near_q16(OneQ16 / 4), near_q16(OneQ16)};
    vals[CFG_ROW2_XY] = '0;
    vals[CFG_ROW2_ZW] = {OneQ16, 32'd0};
    vals[CFG_DIST] = {32'(k0_lo + int'($urandom_range(k0_hi - k0_lo))),
                      32'(int'($urandom_range(1 << 23)) - (1 << 22))};
    vals[CFG_INV_F2] = (64'd1 << 48) / (64'(f) * 64'(f));
  endtask

  point_row_t reset_rows [] = '{
    '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b1,
      '{32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0, 1'b0}},
    '{32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 1'b1, '{'0, '0, 1'b0, 1'b1, 1'b0}},
    '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b1, '{'0, '0, 1'b1, 1'b0, 1'b0}},
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1,
      '{32'hFFFF_0000, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'hFFFF_0000, 32'hFFFF_0000, 1'b1, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, '{'0, '0, 1'b0, 1'b1, 1'b0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'h0003_8000, 32'hFFFC_4000, 32'hFFFD_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_7000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}}
  };

  point_row_t lens_rows [] = '{
    '{32'h0000_8000, 32'h0000_8000, 32'hFFFF_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'h0003_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'h0001_8000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'hFFFE_0000, 32'h0000_4000, 32'h0002_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '{'0, '0, 1'b0, 1'b0, 1'b0}}
  };

  initial begin
    logic [63:0] vals [NumCfg];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROW0_XY;
    cfg_data_i = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    fail_cnt = 0;
    point_cnt = 0;
    image_cnt = 0;
    distorted_cnt = 0;
    dz_cnt = 0;
    for (int i = 0; i < NumCfg; i++) cam_regs[i] = '0;
    cam_regs[CFG_ROW0_XY] = {OneQ16, 32'd0};
    cam_regs[CFG_ROW1_XY] = {32'd0, OneQ16};
    cam_regs[CFG_ROW2_ZW] = {OneQ16, 32'd0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (DrainCycles) @(posedge clk_i);

    foreach (reset_rows[i])
      offer_point(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z, reset_rows[i].known,
                  reset_rows[i].res);
    offer_random(PhaseItems / 2);
    wait_drain();

    camera_regs(vals, -(1 << 23), 1 << 23);
    load_regs(vals);
    foreach (lens_rows[i])
      offer_point(lens_rows[i].x, lens_rows[i].y, lens_rows[i].z, 1'b0, lens_rows[i].res);
    hold_req = 1'b1;
    offer_random(PhaseItems);
    no_idle = 1'b1;
    offer_random(PhaseItems / 2);
    no_idle = 1'b0;
    wait_drain();

    camera_regs(vals, -(3 << 24), -(1 << 23));
    load_regs(vals);
    foreach (lens_rows[i])
      offer_point(lens_rows[i].x, lens_rows[i].y, lens_rows[i].z, 1'b0, lens_rows[i].res);
    offer_random(PhaseItems / 2);
    wait_drain();
    offer_random(PhaseItems / 2);
    wait_drain();

    for (int i = 0; i < NumCfg; i++) vals[i] = '1;
    load_regs(vals);
    offer_random(PhaseItems / 3);
    wait_drain();
    for (int i = 0; i < NumCfg; i++) vals[i] = 64'h8000_0000_7FFF_FFFF;
    vals[CFG_DIST] = 64'h7FFF_FFFF_8000_0000;
    load_regs(vals);
    offer_random(PhaseItems / 3);
    wait_drain();
    for (int i = 0; i < NumCfg; i++) vals[i] = '0;
    load_regs(vals);
    offer_random(PhaseItems / 4);
    wait_drain();

    for (int i = 0; i < NumCfg; i++) vals[i] = {$urandom, $urandom};
    load_regs(vals);
    offer_random(PhaseItems);
    wait_drain();

    $display("%0d points sent, %0d images checked under seven register settings",
             point_cnt, image_cnt);
    $display("%0d images distorted, %0d at zero depth", distorted_cnt, dz_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
